/* design/piir_pkg.sv */
`timescale 1ns / 1ps

package piir_pkg;

  localparam int COEF_W   = 18;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 6;
  localparam int W_W      = 32;
  localparam int ACC_W    = 51;
  localparam int SUM_W    = 52;
  localparam int CNT_W    = 5;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [W_W-1:0]    hist_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic  load;
    logic  clear;
    coef_t mplier;
    acc_t  mcand;
  } mac_ctrl_t;

  localparam sum_t S32_MAX = SUM_W'(64'sd2147483647);
  localparam sum_t S32_MIN = -SUM_W'(64'sd2147483648);

endpackage

/* design/piir_mac.sv */
`timescale 1ns / 1ps

module piir_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  piir_pkg::mac_ctrl_t ctrl_i,
  output piir_pkg::acc_t      acc_o,
  output logic                done_o
);
  import piir_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  coef_t             mplier_q;
  acc_t              mcand_q;
  acc_t              acc_q;
  logic              last;

  assign last = (cnt_q == CNT_W'(COEF_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (ctrl_i.load) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // one multiplier bit per cycle; the sign bit weighs negative
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mplier_q <= ctrl_i.mplier;
      mcand_q  <= ctrl_i.mcand;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= last ? (acc_q - mcand_q) : (acc_q + mcand_q);
      end
      mplier_q <= mplier_q >>> 1;
      mcand_q  <= mcand_q <<< 1;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

/* design/piir_coef_mem.sv */
`timescale 1ns / 1ps

module piir_coef_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  piir_pkg::coef_t     wdata_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output piir_pkg::coef_t     rdata_o
);
  import piir_pkg::*;

  coef_t            mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  coef_t            rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

/* design/piir_hist_mem.sv */
`timescale 1ns / 1ps

module piir_hist_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  piir_pkg::hist_t     w1_i,
  input  piir_pkg::hist_t     w2_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output piir_pkg::hist_t     w1_o,
  output piir_pkg::hist_t     w2_o
);
  import piir_pkg::*;

  hist_t            w1_mem_q [DEPTH];
  hist_t            w2_mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  hist_t            w1_q;
  hist_t            w2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      w1_mem_q[waddr_i] <= w1_i;
      w2_mem_q[waddr_i] <= w2_i;
    end
    w1_q <= valid_q[raddr_i] ? w1_mem_q[raddr_i] : '0;
    w2_q <= valid_q[raddr_i] ? w2_mem_q[raddr_i] : '0;
  end

  assign w1_o = w1_q;
  assign w2_o = w2_q;

endmodule

/* design/parallel_iir_filter.sv */
`timescale 1ns / 1ps

// Parallel-form IIR filter, SECTIONS second-order sections on one sample.
// Input stream: tuser is the command (0 filter a sample, 1 load a
// coefficient); tdata carries sample, coefficient index and value.
// Output stream: tdata is the filtered word, tuser flags saturation.
// A load gives no output word.
// A sample runs through one shared bit-serial multiplier, one coefficient
// bit per cycle: the gain product once, then per section a coefficient and
// history fetch, the two feedback products, a history update and the two
// feed-forward products.
// The input is ready only while no sample is in work. A finished word sits
// in the output register; a stalled receiver holds it there, and the next
// sample is accepted meanwhile but waits before its own word is written.
// Reset clears coefficients and history to zero, gain to 6.0, and empties
// the output register. The gain register is written through cfg_we_i.
module parallel_iir_filter #(
  parameter int SECTIONS  = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [17:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // sample[15:0], coef_index[21:16], coef_value[39:22]
  input  logic        s_axis_tuser_i,  // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // filtered
  output logic        m_axis_tuser_o   // saturated
);
  import piir_pkg::*;

  localparam int COEFS = SECTIONS * 4;
  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CA_W  = SEC_W + 2;
  localparam int EXT_W = 10;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_WN    = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [2:0] SEL_GAIN = 3'd0;
  localparam logic [2:0] SEL_A1   = 3'd1;
  localparam logic [2:0] SEL_A2   = 3'd2;
  localparam logic [2:0] SEL_B1   = 3'd3;
  localparam logic [2:0] SEL_B2   = 3'd4;

  logic [2:0]       state_q;
  logic [2:0]       sel_q;
  logic [SEC_W-1:0] sec_q;
  logic [2:0]       fetch_q;
  coef_t            gain_q;
  logic signed [SAMPLE_W-1:0] x_q;
  coef_t            a1_q, a2_q, b1_q, b2_q;
  hist_t            w1_q, w2_q;
  sum_t             sum_q;
  logic             clip_q;
  logic             out_valid_q;
  logic [31:0]      out_data_q;
  logic             out_sat_q;

  logic             in_acc;
  logic [EXT_W-1:0] idx_ext;
  logic             coef_we;
  coef_t            coef_rdata;
  hist_t            hist_w1, hist_w2;
  logic             hist_we;
  hist_t            wn;
  logic             wn_clip;
  sum_t             wn_wide;
  sum_t             acc_term;
  sum_t             sum_next;
  logic [31:0]      out_clamped;
  logic             out_clip;
  mac_ctrl_t        mac_ctrl;
  acc_t             mac_acc;
  logic             mac_done;
  logic             sec_last;
  logic             out_load;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_ext         = EXT_W'(s_axis_tdata_i[21:16]);
  assign coef_we         = in_acc && s_axis_tuser_i && (idx_ext < EXT_W'(COEFS));
  assign sec_last        = (sec_q == SEC_W'(SECTIONS - 1));
  assign out_load        = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  assign acc_term = SUM_W'(mac_acc >>> FRAC_BITS);
  assign wn_wide  = SUM_W'(x_q) - acc_term;
  assign sum_next = sum_q + acc_term;

  always_comb begin
    wn_clip = 1'b1;
    if (wn_wide > S32_MAX) begin
      wn = hist_t'(S32_MAX);
    end else if (wn_wide < S32_MIN) begin
      wn = hist_t'(S32_MIN);
    end else begin
      wn      = hist_t'(wn_wide);
      wn_clip = 1'b0;
    end
  end

  always_comb begin
    out_clip = 1'b1;
    if (sum_q > S32_MAX) begin
      out_clamped = 32'(S32_MAX);
    end else if (sum_q < S32_MIN) begin
      out_clamped = 32'(S32_MIN);
    end else begin
      out_clamped = 32'(sum_q);
      out_clip    = 1'b0;
    end
  end

  always_comb begin
    mac_ctrl        = '0;
    mac_ctrl.mplier = a1_q;
    mac_ctrl.mcand  = ACC_W'(w1_q);
    case (state_q)
      ST_IDLE: begin
        mac_ctrl.load   = in_acc && !s_axis_tuser_i;
        mac_ctrl.clear  = 1'b1;
        mac_ctrl.mplier = gain_q;
        mac_ctrl.mcand  = ACC_W'(signed'(s_axis_tdata_i[15:0]));
      end
      ST_FETCH: begin
        mac_ctrl.load  = (fetch_q == 3'd4);
        mac_ctrl.clear = 1'b1;
      end
      ST_MAC: begin
        case (sel_q)
          SEL_A1: begin
            mac_ctrl.load   = mac_done;
            mac_ctrl.mplier = a2_q;
            mac_ctrl.mcand  = ACC_W'(w2_q);
          end
          SEL_B1: begin
            mac_ctrl.load   = mac_done;
            mac_ctrl.mplier = b2_q;
            mac_ctrl.mcand  = ACC_W'(w1_q);
          end
          default: begin
            mac_ctrl.load = 1'b0;
          end
        endcase
      end
      ST_WN: begin
        mac_ctrl.load   = 1'b1;
        mac_ctrl.clear  = 1'b1;
        mac_ctrl.mplier = b1_q;
        mac_ctrl.mcand  = ACC_W'(wn);
      end
      default: begin
        mac_ctrl.load = 1'b0;
      end
    endcase
  end

  assign hist_we = (state_q == ST_WN);

  piir_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  piir_coef_mem #(
    .DEPTH  (COEFS),
    .ADDR_W (CA_W)
  ) u_coef_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (coef_we),
    .waddr_i (idx_ext[CA_W-1:0]),
    .wdata_i (coef_t'(s_axis_tdata_i[39:22])),
    .raddr_i ({sec_q, fetch_q[1:0]}),
    .rdata_o (coef_rdata)
  );

  piir_hist_mem #(
    .DEPTH  (SECTIONS),
    .ADDR_W (SEC_W)
  ) u_hist_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (hist_we),
    .waddr_i (sec_q),
    .w1_i    (wn),
    .w2_i    (w1_q),
    .raddr_i (sec_q),
    .w1_o    (hist_w1),
    .w2_o    (hist_w2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= SEL_GAIN;
      sec_q       <= '0;
      fetch_q     <= '0;
      gain_q      <= coef_t'(24576);
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= coef_t'(cfg_wdata_i);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && !s_axis_tuser_i) begin
            clip_q  <= 1'b0;
            sel_q   <= SEL_GAIN;
            state_q <= ST_MAC;
          end
        end
        ST_FETCH: begin
          fetch_q <= fetch_q + 3'd1;
          if (fetch_q == 3'd4) begin
            sel_q   <= SEL_A1;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (mac_done) begin
            case (sel_q)
              SEL_GAIN: begin
                sec_q   <= '0;
                fetch_q <= '0;
                state_q <= ST_FETCH;
              end
              SEL_A1: sel_q <= SEL_A2;
              SEL_A2: state_q <= ST_WN;
              SEL_B1: sel_q <= SEL_B2;
              default: begin
                fetch_q <= '0;
                if (sec_last) begin
                  state_q <= ST_OUT;
                end else begin
                  sec_q   <= sec_q + SEC_W'(1);
                  state_q <= ST_FETCH;
                end
              end
            endcase
          end
        end
        ST_WN: begin
          clip_q  <= clip_q | wn_clip;
          sel_q   <= SEL_B1;
          state_q <= ST_MAC;
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= signed'(s_axis_tdata_i[15:0]);
    end
    if (state_q == ST_FETCH) begin
      case (fetch_q)
        3'd1: begin
          a1_q <= coef_rdata;
          w1_q <= hist_w1;
          w2_q <= hist_w2;
        end
        3'd2: a2_q <= coef_rdata;
        3'd3: b1_q <= coef_rdata;
        3'd4: b2_q <= coef_rdata;
        default: begin
        end
      endcase
    end
    if ((state_q == ST_MAC) && mac_done) begin
      if (sel_q == SEL_GAIN) begin
        sum_q <= acc_term;
      end else if (sel_q == SEL_B2) begin
        sum_q <= sum_next;
      end
    end
    if (out_load) begin
      out_data_q <= out_clamped;
      out_sat_q  <= clip_q | out_clip;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import piir_pkg::*;

  localparam int SECTIONS  = 16;
  localparam int FRAC_BITS = 12;
  localparam int LATENCY   = 20 + 82 * SECTIONS + 60;
  localparam int STALL_LIMIT = 20000;
  localparam bit CMD_FILTER = 1'b0;
  localparam bit CMD_LOAD   = 1'b1;
  localparam longint OUT_MAX = 64'sd2147483647;
  localparam longint OUT_MIN = -64'sd2147483648;

  typedef struct {
    logic [31:0] filtered;
    logic        saturated;
  } filter_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [17:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;  // sample[15:0], coef_index[21:16], coef_value[39:22]
  logic        s_axis_tuser_i = 1'b0;  // command
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;  // filtered
  logic        m_axis_tuser_o;  // saturated

  parallel_iir_filter #(.SECTIONS(SECTIONS), .FRAC_BITS(FRAC_BITS)) DUT (.*);

  longint       gain_q = 24576;
  longint       coef_q[SECTIONS*4];
  longint       w1_q[SECTIONS];
  longint       w2_q[SECTIONS];
  filter_word_t expected_q[$];

  bit     tx_gaps = 1'b0;
  bit     rx_gaps = 1'b0;
  int     rx_hold = 0;
  int     err_cnt = 0;
  int     idle_cycles = 0;
  int     n_samples = 0;
  int     n_loads = 0;
  int     n_words = 0;
  int     n_clipped = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clamp_word(longint v, ref bit clip);
    if (v > OUT_MAX) begin
      clip = 1'b1;
      return OUT_MAX;
    end
    if (v < OUT_MIN) begin
      clip = 1'b1;
      return OUT_MIN;
    end
    return v;
  endfunction

  function automatic void run_filter(logic cmd, logic [15:0] smp, logic [5:0] idx,
                                     logic [17:0] val);
    longint x;
    longint acc;
    longint wn;
    longint old_w1;
    bit clip;
    filter_word_t r;
    if (cmd == CMD_LOAD) begin
      if (idx < SECTIONS * 4) coef_q[idx] = longint'($signed(val));
      n_loads++;
      return;
    end
    clip = 1'b0;
    x = longint'($signed(smp));
    acc = (gain_q * x) >>> FRAC_BITS;
    for (int s = 0; s < SECTIONS; s++) begin
      old_w1 = w1_q[s];
      wn = x - ((coef_q[4*s] * w1_q[s] + coef_q[4*s+1] * w2_q[s]) >>> FRAC_BITS);
      wn = clamp_word(wn, clip);
      w2_q[s] = old_w1;
      w1_q[s] = wn;
      acc += (coef_q[4*s+2] * wn + coef_q[4*s+3] * old_w1) >>> FRAC_BITS;
    end
    acc = clamp_word(acc, clip);
    r.filtered = acc[31:0];
    r.saturated = clip;
    expected_q.push_back(r);
    n_samples++;
  endfunction

  task automatic send_word(logic cmd, logic [15:0] smp, logic [5:0] idx, logic [17:0] val);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {val, idx, smp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    run_filter(cmd, smp, idx, val);
  endtask

  task automatic end_stream();
    s_axis_tvalid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [17:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    gain_q = longint'($signed(v));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_coef(int idx, logic [17:0] v);
    send_word(CMD_LOAD, 16'($urandom), idx[5:0], v);
  endtask

  task automatic filter_sample(logic [15:0] smp);
    send_word(CMD_FILTER, smp, 6'($urandom), 18'($urandom));
  endtask

  task automatic test_directed();
    filter_sample(16'h7fff);
    filter_sample(16'h8000);
    filter_sample(16'h0000);
    filter_sample(16'hffff);
    load_coef(0, 18'h20000);
    load_coef(1, 18'h1ffff);
    load_coef(2, 18'h1ffff);
    load_coef(3, 18'h20000);
    load_coef(63, 18'h1ffff);
    for (int i = 0; i < 6; i++) filter_sample(i[0] ? 16'h8000 : 16'h7fff);
    for (int s = 1; s < SECTIONS; s++) load_coef(4*s + 2, 18'h1ffff);
    filter_sample(16'h7fff);
    filter_sample(16'h8000);
    end_stream();
  endtask

  task automatic test_gain();
    logic [17:0] g[4] = '{18'h20000, 18'h1ffff, 18'h00000, 18'h00800};
    for (int i = 0; i < 4; i++) begin
      write_gain(g[i]);
      filter_sample(16'h7fff);
      filter_sample(16'h8000);
      filter_sample(16'($urandom));
      end_stream();
    end
  endtask

  task automatic random_items(int count);
    logic [17:0] v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 9) < 7) v = 18'($signed($urandom_range(0, 4095)) - 2048);
        else v = 18'($urandom);
        load_coef($urandom_range(0, 63), v);
      end else begin
        filter_sample(16'($urandom));
      end
    end
  endtask

  task automatic test_random();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    random_items(800);
    end_stream();
    write_gain(18'($urandom));
    random_items(850);
    end_stream();
  endtask

  task automatic test_backpressure();
    rx_hold = 3000;
    for (int i = 0; i < 6; i++) filter_sample(16'($urandom));
    end_stream();
  endtask

  task automatic test_no_gaps();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_gain(18'd24576);
    random_items(120);
    end_stream();
  endtask

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      repeat (rx_hold) @(posedge clk_i);
      rx_hold = 0;
    end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
      m_axis_tready_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    filter_word_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected word: filtered %0d saturated %0b",
               $signed(m_axis_tdata_o), m_axis_tuser_o);
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        n_words++;
        if (e.saturated) n_clipped++;
        if (m_axis_tdata_o !== e.filtered) begin
          $error("filtered: expected %0d actual %0d", $signed(e.filtered),
                 $signed(m_axis_tdata_o));
          err_cnt++;
        end
        if (m_axis_tuser_o !== e.saturated) begin
          $error("saturated: expected %0b actual %0b", e.saturated, m_axis_tuser_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("** parallel_iir_filter: FAILED **");
      $finish;
    end
  end

  initial begin
    foreach (coef_q[i]) coef_q[i] = 0;
    foreach (w1_q[i]) begin
      w1_q[i] = 0;
      w2_q[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_gain();
    test_random();
    test_backpressure();
    test_no_gaps();
    $display("covered %0d samples and %0d coefficient loads", n_samples, n_loads);
    $display("checked %0d output words, %0d of them saturated", n_words, n_clipped);
    if (err_cnt == 0) begin
      $display("** parallel_iir_filter: PASSED **");
    end else begin
      $display("** parallel_iir_filter: FAILED **");
    end
    $finish;
  end

endmodule
